FILE: hdl/tpsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsw_pkg
// Types and constants shared by the thin-plate spline warp core.
// ----------------------------------------------------------------------------
package tpsw_pkg;

   localparam int DEFAULT_MAX_POINTS = 64;

   localparam int NUM_W   = 7;
   localparam int CFG_W   = 32;
   localparam int IDX_W   = 6;
   localparam int PT_W    = 16;
   localparam int WGT_W   = 40;
   localparam int PIX_W   = 12;
   localparam int OUT_W   = 24;
   localparam int ADDR_W  = 5;

   // Squared distance in Q.8 fits 33 bits; exponent index needs 6 bits.
   localparam int R_W     = 33;
   localparam int E_W     = 6;
   localparam int M_W     = 31;
   localparam int FRAC_W  = 16;
   localparam int LOG_W   = 23;
   localparam int LN_W    = 24;
   localparam int K_W     = 43;
   localparam int WH_W    = 24;
   localparam int B_W     = K_W + 17;
   localparam int A_W     = K_W + WH_W;
   localparam int TERM_W  = A_W - 16;
   localparam int AFF_W   = 48;
   localparam int SQ_STEPS = 16;

   localparam logic signed [30:0] LN2_Q30 = 31'sd744261118;
   localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
   localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

   localparam logic [CFG_W-1:0] AFF_ONE = 32'h0100_0000;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   localparam logic [2:0] REG_NUM_POINTS = 3'd0;
   localparam logic [2:0] REG_U_OFFSET   = 3'd1;
   localparam logic [2:0] REG_U_X        = 3'd2;
   localparam logic [2:0] REG_U_Y        = 3'd3;
   localparam logic [2:0] REG_V_OFFSET   = 3'd4;
   localparam logic [2:0] REG_V_X        = 3'd5;
   localparam logic [2:0] REG_V_Y        = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE, ST_AFF1, ST_AFF2, ST_RD, ST_DSQ, ST_SUM, ST_NORM, ST_SQ,
      ST_LN, ST_KMUL, ST_BMUL, ST_AMUL, ST_TERM, ST_ACC, ST_FIN
   } ctl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_START, OP_AFF1, OP_AFF2, OP_RD, OP_DSQ, OP_SUM,
      OP_NORM, OP_SQ, OP_LN, OP_KMUL, OP_BMUL, OP_AMUL, OP_TERM, OP_ACC, OP_FIN
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_sts_type;

   typedef struct packed {
      logic signed [CFG_W-1:0] u_offset;
      logic signed [CFG_W-1:0] u_x;
      logic signed [CFG_W-1:0] u_y;
      logic signed [CFG_W-1:0] v_offset;
      logic signed [CFG_W-1:0] v_x;
      logic signed [CFG_W-1:0] v_y;
   } affine_type;

   typedef struct packed {
      logic [PT_W-1:0]         px;
      logic [PT_W-1:0]         py;
      logic signed [WGT_W-1:0] wu;
      logic signed [WGT_W-1:0] wv;
   } entry_type;

endpackage

FILE: hdl/tpsw_ctl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsw_ctl
// Sequencer: walks the control point table one point at a time and issues
// datapath operations.
// ----------------------------------------------------------------------------
module tpsw_ctl #(
   parameter int MAX_POINTS = tpsw_pkg::DEFAULT_MAX_POINTS,
   parameter int AW = 6,
   parameter int CW = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_type,
   output logic                        req_stall,
   input  logic [tpsw_pkg::NUM_W-1:0]  num_points,
   input  tpsw_pkg::dp_sts_type        sts,
   output tpsw_pkg::dp_cmd_type        cmd,
   output logic [AW-1:0]               rd_addr
);
   import tpsw_pkg::*;

   ctl_state_type state_ff, state_in;
   logic [CW-1:0] j_ff, j_in, n_ff, n_in;
   logic [3:0]    it_ff, it_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         j_ff     <= '0;
         n_ff     <= '0;
         it_ff    <= '0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         n_ff     <= n_in;
         it_ff    <= it_in;
      end
   end

   assign rd_addr = AW'(j_ff);

   always_comb begin
      state_in  = state_ff;
      j_in      = j_ff;
      n_in      = n_ff;
      it_in     = it_ff;
      cmd.op    = OP_NONE;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_LOAD) begin
                  cmd.op = OP_LOAD;
               end else begin
                  cmd.op   = OP_START;
                  j_in     = '0;
                  n_in     = (int'(num_points) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                             : CW'(num_points);
                  state_in = ST_AFF1;
               end
            end
         end
         ST_AFF1: begin
            cmd.op   = OP_AFF1;
            state_in = ST_AFF2;
         end
         ST_AFF2: begin
            cmd.op   = OP_AFF2;
            state_in = (n_ff == '0) ? ST_FIN : ST_RD;
         end
         ST_RD: begin
            cmd.op   = OP_RD;
            state_in = ST_DSQ;
         end
         ST_DSQ: begin
            cmd.op   = OP_DSQ;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            cmd.op   = OP_NORM;
            it_in    = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.op = OP_SQ;
            it_in  = it_ff + 4'd1;
            if (it_ff == 4'(SQ_STEPS - 1)) begin
               state_in = ST_LN;
            end
         end
         ST_LN: begin
            cmd.op   = OP_LN;
            state_in = ST_KMUL;
         end
         ST_KMUL: begin
            cmd.op   = OP_KMUL;
            state_in = ST_BMUL;
         end
         ST_BMUL: begin
            cmd.op   = OP_BMUL;
            state_in = ST_AMUL;
         end
         ST_AMUL: begin
            cmd.op   = OP_AMUL;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            cmd.op   = OP_TERM;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op   = OP_ACC;
            j_in     = j_ff + 1'b1;
            state_in = (j_ff + 1'b1 == n_ff) ? ST_FIN : ST_RD;
         end
         ST_FIN: begin
            if (!sts.out_busy) begin
               cmd.op   = OP_FIN;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/tpsw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsw_dp
// Datapath: point table, distance, log2 by repeated squaring, kernel and
// weight products, accumulators and the result register.
// ----------------------------------------------------------------------------
module tpsw_dp #(
   parameter int MAX_POINTS = tpsw_pkg::DEFAULT_MAX_POINTS,
   parameter int AW = 6,
   parameter int ACC_W = 58
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tpsw_pkg::dp_cmd_type               cmd,
   output tpsw_pkg::dp_sts_type               sts,
   input  logic [AW-1:0]                      rd_addr,
   input  tpsw_pkg::affine_type               aff,
   input  logic [tpsw_pkg::IDX_W-1:0]         req_entry_index,
   input  logic [tpsw_pkg::PT_W-1:0]          req_point_x,
   input  logic [tpsw_pkg::PT_W-1:0]          req_point_y,
   input  logic signed [tpsw_pkg::WGT_W-1:0]  req_weight_u,
   input  logic signed [tpsw_pkg::WGT_W-1:0]  req_weight_v,
   input  logic [tpsw_pkg::PIX_W-1:0]         req_pixel_x,
   input  logic [tpsw_pkg::PIX_W-1:0]         req_pixel_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [tpsw_pkg::OUT_W-1:0]  rsp_map_u,
   output logic signed [tpsw_pkg::OUT_W-1:0]  rsp_map_v,
   output logic                               rsp_saturated
);
   import tpsw_pkg::*;

   entry_type mem [MAX_POINTS];
   entry_type ent_ff;

   logic [PIX_W-1:0] pxl_x_ff, pxl_y_ff;
   logic signed [AFF_W-1:0] pux_ff, puy_ff, pvx_ff, pvy_ff;
   logic signed [ACC_W-1:0] acc_u_ff, acc_v_ff;
   logic [2*PT_W+1:0] dx2_ff, dy2_ff;
   logic [R_W-1:0]    r_ff;
   logic              zero_ff;
   logic [E_W-1:0]    e_ff;
   logic [M_W-1:0]    m_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic signed [LN_W-1:0] ln_ff;
   logic signed [K_W-1:0]  k_ff;
   logic signed [B_W-1:0]  bu_ff, bv_ff;
   logic signed [A_W-1:0]  au_ff, av_ff;
   logic signed [TERM_W-1:0] tu_ff, tv_ff;
   logic rsp_valid_ff;
   logic signed [OUT_W-1:0] map_u_ff, map_v_ff;
   logic sat_ff;

   logic signed [PT_W+1:0] dx, dy;
   logic signed [2*PT_W+3:0] dx2, dy2;
   logic [E_W-1:0] e_c;
   logic [R_W+M_W-2:0] shifted;
   logic [2*M_W-1:0] msq;
   logic [M_W:0] mnext;
   logic signed [LOG_W-1:0] lval;
   logic signed [LOG_W+30:0] lnprod;
   logic signed [R_W+LN_W:0] kprod;
   logic signed [AFF_W-1:0] au_sum, av_sum;
   logic signed [ACC_W-1:0] fin_u, fin_v;
   logic sat_u, sat_v;

   // Table write and registered read.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && int'(req_entry_index) < MAX_POINTS) begin
         mem[AW'(req_entry_index)] <= '{px: req_point_x, py: req_point_y,
                                        wu: req_weight_u, wv: req_weight_v};
      end
      if (cmd.op == OP_RD) begin
         ent_ff <= mem[rd_addr];
      end
   end

   assign dx = $signed({2'b0, pxl_x_ff, 4'b0}) - $signed({2'b0, ent_ff.px});
   assign dy = $signed({2'b0, pxl_y_ff, 4'b0}) - $signed({2'b0, ent_ff.py});
   assign dx2 = dx * dx;
   assign dy2 = dy * dy;

   always_comb begin
      e_c = '0;
      for (int i = 0; i < R_W; i++) begin
         if (r_ff[i]) begin
            e_c = E_W'(i);
         end
      end
   end

   // Normalize to Q1.30: left shift below bit 30, truncating right shift above.
   assign shifted = {r_ff, 30'b0} >> e_c;
   assign msq     = m_ff * m_ff;
   assign mnext   = (M_W + 1)'(msq >> 30);
   assign lval    = $signed({1'b0, e_ff, frac_ff}) - LOG_W'(8 * 65536);
   assign lnprod  = lval * LN2_Q30;
   assign kprod   = $signed({2'b0, r_ff}) * ln_ff;
   assign au_sum  = pux_ff + puy_ff + (AFF_W'(aff.u_offset) <<< 8);
   assign av_sum  = pvx_ff + pvy_ff + (AFF_W'(aff.v_offset) <<< 8);

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_START: begin
            pxl_x_ff <= req_pixel_x;
            pxl_y_ff <= req_pixel_y;
         end
         OP_AFF1: begin
            pux_ff <= AFF_W'(aff.u_x * $signed({1'b0, pxl_x_ff}));
            puy_ff <= AFF_W'(aff.u_y * $signed({1'b0, pxl_y_ff}));
            pvx_ff <= AFF_W'(aff.v_x * $signed({1'b0, pxl_x_ff}));
            pvy_ff <= AFF_W'(aff.v_y * $signed({1'b0, pxl_y_ff}));
         end
         OP_AFF2: begin
            acc_u_ff <= ACC_W'(au_sum >>> 16);
            acc_v_ff <= ACC_W'(av_sum >>> 16);
         end
         OP_DSQ: begin
            dx2_ff <= (2*PT_W+2)'(dx2);
            dy2_ff <= (2*PT_W+2)'(dy2);
         end
         OP_SUM: begin
            r_ff <= R_W'(dx2_ff + dy2_ff);
         end
         OP_NORM: begin
            zero_ff <= (r_ff == '0);
            e_ff    <= e_c;
            m_ff    <= M_W'(shifted);
            frac_ff <= '0;
         end
         OP_SQ: begin
            if (mnext[M_W]) begin
               m_ff    <= mnext[M_W:1];
               frac_ff <= {frac_ff[FRAC_W-2:0], 1'b1};
            end else begin
               m_ff    <= mnext[M_W-1:0];
               frac_ff <= {frac_ff[FRAC_W-2:0], 1'b0};
            end
         end
         OP_LN: begin
            ln_ff <= LN_W'(lnprod >>> 30);
         end
         OP_KMUL: begin
            k_ff <= K_W'(kprod >>> 16);
         end
         OP_BMUL: begin
            bu_ff <= B_W'(k_ff * $signed({1'b0, ent_ff.wu[15:0]}));
            bv_ff <= B_W'(k_ff * $signed({1'b0, ent_ff.wv[15:0]}));
         end
         OP_AMUL: begin
            au_ff <= k_ff * $signed(ent_ff.wu[WGT_W-1:16]);
            av_ff <= k_ff * $signed(ent_ff.wv[WGT_W-1:16]);
         end
         OP_TERM: begin
            tu_ff <= TERM_W'((au_ff + A_W'(bu_ff >>> 16)) >>> 16);
            tv_ff <= TERM_W'((av_ff + A_W'(bv_ff >>> 16)) >>> 16);
         end
         OP_ACC: begin
            // A point sitting exactly on the pixel contributes nothing.
            if (!zero_ff) begin
               acc_u_ff <= acc_u_ff + ACC_W'(tu_ff);
               acc_v_ff <= acc_v_ff + ACC_W'(tv_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign sat_u = (acc_u_ff > ACC_W'(OUT_MAX)) || (acc_u_ff < ACC_W'(OUT_MIN));
   assign sat_v = (acc_v_ff > ACC_W'(OUT_MAX)) || (acc_v_ff < ACC_W'(OUT_MIN));
   assign fin_u = (acc_u_ff > ACC_W'(OUT_MAX)) ? ACC_W'(OUT_MAX) :
                  (acc_u_ff < ACC_W'(OUT_MIN)) ? ACC_W'(OUT_MIN) : acc_u_ff;
   assign fin_v = (acc_v_ff > ACC_W'(OUT_MAX)) ? ACC_W'(OUT_MAX) :
                  (acc_v_ff < ACC_W'(OUT_MIN)) ? ACC_W'(OUT_MIN) : acc_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_FIN) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_FIN) begin
         map_u_ff <= OUT_W'(fin_u);
         map_v_ff <= OUT_W'(fin_v);
         sat_ff   <= sat_u || sat_v;
      end
   end

   assign sts.out_busy  = rsp_valid_ff && rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_map_u     = map_u_ff;
   assign rsp_map_v     = map_v_ff;
   assign rsp_saturated = sat_ff;

endmodule

FILE: hdl/thin_plate_spline_warp_eval_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thin_plate_spline_warp_eval_core
// Thin-plate spline warp evaluator with register file, sequencer and datapath.
// ----------------------------------------------------------------------------
//  Channel | Ports     | Direction | Moves
//  req     | req_*     | in        | one load or evaluate word
//  rsp     | rsp_*     | out       | one mapped (u, v) word per evaluate
//  csr     | csr_*     | in/out    | register writes and reads, pready high
//
// A load word does not make the sequencer busy. An evaluate word walks the
// points one at a time, N being the number of points in use; each point
// passes through the single shared log/multiply datapath and its squaring loop.
// Synchronous reset clears the registers and control; table contents are
// undefined until loaded. A finished word waits in the output register while
// the next request is taken; the sequencer holds only if that word is still
// stalled when the next result is ready.
module thin_plate_spline_warp_eval_core #(
   parameter int MAX_POINTS = tpsw_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [tpsw_pkg::IDX_W-1:0]         req_entry_index,
   input  logic [tpsw_pkg::PT_W-1:0]          req_point_x,
   input  logic [tpsw_pkg::PT_W-1:0]          req_point_y,
   input  logic signed [tpsw_pkg::WGT_W-1:0]  req_weight_u,
   input  logic signed [tpsw_pkg::WGT_W-1:0]  req_weight_v,
   input  logic [tpsw_pkg::PIX_W-1:0]         req_pixel_x,
   input  logic [tpsw_pkg::PIX_W-1:0]         req_pixel_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [tpsw_pkg::OUT_W-1:0]  rsp_map_u,
   output logic signed [tpsw_pkg::OUT_W-1:0]  rsp_map_v,
   output logic                               rsp_saturated,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tpsw_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [tpsw_pkg::CFG_W-1:0]         csr_pwdata,
   output logic [tpsw_pkg::CFG_W-1:0]         csr_prdata,
   output logic                               csr_pready
);
   import tpsw_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int ACC_W = TERM_W + $clog2(MAX_POINTS + 1) + 2;

   logic [NUM_W-1:0] num_ff;
   affine_type aff_ff;
   logic wr_en;
   logic [2:0] reg_idx;
   dp_cmd_type cmd;
   dp_sts_type sts;
   logic [AW-1:0] rd_addr;

   assign csr_pready = 1'b1;
   assign wr_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff          <= '0;
         aff_ff.u_offset <= '0;
         aff_ff.u_x      <= AFF_ONE;
         aff_ff.u_y      <= '0;
         aff_ff.v_offset <= '0;
         aff_ff.v_x      <= '0;
         aff_ff.v_y      <= AFF_ONE;
      end else if (wr_en) begin
         case (reg_idx)
            REG_NUM_POINTS: num_ff          <= csr_pwdata[NUM_W-1:0];
            REG_U_OFFSET:   aff_ff.u_offset <= csr_pwdata;
            REG_U_X:        aff_ff.u_x      <= csr_pwdata;
            REG_U_Y:        aff_ff.u_y      <= csr_pwdata;
            REG_V_OFFSET:   aff_ff.v_offset <= csr_pwdata;
            REG_V_X:        aff_ff.v_x      <= csr_pwdata;
            REG_V_Y:        aff_ff.v_y      <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_NUM_POINTS: csr_prdata = CFG_W'(num_ff);
         REG_U_OFFSET:   csr_prdata = aff_ff.u_offset;
         REG_U_X:        csr_prdata = aff_ff.u_x;
         REG_U_Y:        csr_prdata = aff_ff.u_y;
         REG_V_OFFSET:   csr_prdata = aff_ff.v_offset;
         REG_V_X:        csr_prdata = aff_ff.v_x;
         REG_V_Y:        csr_prdata = aff_ff.v_y;
         default:        csr_prdata = '0;
      endcase
   end

   tpsw_ctl #(.MAX_POINTS(MAX_POINTS), .AW(AW), .CW(CW)) u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_type   (req_type),
      .req_stall  (req_stall),
      .num_points (num_ff),
      .sts        (sts),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   tpsw_dp #(.MAX_POINTS(MAX_POINTS), .AW(AW), .ACC_W(ACC_W)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .rd_addr         (rd_addr),
      .aff             (aff_ff),
      .req_entry_index (req_entry_index),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_weight_u    (req_weight_u),
      .req_weight_v    (req_weight_v),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_map_u       (rsp_map_u),
      .rsp_map_v       (rsp_map_v),
      .rsp_saturated   (rsp_saturated)
   );

   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type == REQ_LOAD) |=> !req_stall)
      else $error("load word did not complete in one cycle");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type == REQ_EVAL) |=> req_stall)
      else $error("sequencer did not start on an evaluate word");

   a_num_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && reg_idx == REG_NUM_POINTS) |=> num_ff == $past(csr_pwdata[NUM_W-1:0]))
      else $error("point count register write lost");

endmodule

FILE: sim/tps_warp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_warp_checker
// Watches the request, result and register ports of the spline warp core,
// keeps its own copy of the point table and the affine registers, predicts
// the mapped (u, v) word for every evaluate word and compares each result.
// ----------------------------------------------------------------------------
module tps_warp_checker #(
   parameter int MAX_POINTS = tpsw_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_type,
   input  logic [tpsw_pkg::IDX_W-1:0]         req_entry_index,
   input  logic [tpsw_pkg::PT_W-1:0]          req_point_x,
   input  logic [tpsw_pkg::PT_W-1:0]          req_point_y,
   input  logic signed [tpsw_pkg::WGT_W-1:0]  req_weight_u,
   input  logic signed [tpsw_pkg::WGT_W-1:0]  req_weight_v,
   input  logic [tpsw_pkg::PIX_W-1:0]         req_pixel_x,
   input  logic [tpsw_pkg::PIX_W-1:0]         req_pixel_y,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [tpsw_pkg::OUT_W-1:0]  rsp_map_u,
   input  logic signed [tpsw_pkg::OUT_W-1:0]  rsp_map_v,
   input  logic                               rsp_saturated,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic                               csr_pready,
   input  logic [tpsw_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [tpsw_pkg::CFG_W-1:0]         csr_pwdata,
   output int                                 fail_count,
   output int                                 pending
);
   import tpsw_pkg::*;

   typedef struct packed {
      logic signed [OUT_W-1:0] map_u;
      logic signed [OUT_W-1:0] map_v;
      logic                    sat;
   } warp_word_type;

   logic [NUM_W-1:0] num_points;
   affine_type       affine;
   entry_type        point_table [MAX_POINTS];
   warp_word_type    expected_warps [$];

   assign pending = expected_warps.size();

   // log2 of a nonzero squared distance in Q.16, by repeated squaring.
   function automatic longint log2_q16(longint r);
      longint m;
      longint frac;
      int     e;
      e = 0;
      frac = 0;
      while (e < 63 && (r >> (e + 1)) != 0) e++;
      if (e <= 30) m = r << (30 - e);
      else m = r >> (e - 30);
      for (int i = 0; i < SQ_STEPS; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'sd1 << 31)) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return longint'(e) * 65536 + frac;
   endfunction

   // Weighted r2*ln(r2) term in Q.8; a point sitting on the pixel adds nothing.
   function automatic longint kernel_term(longint r, longint w);
      longint l, ln, k, wh, wl;
      if (r == 0) return 0;
      l = log2_q16(r) - 8 * 65536;
      ln = (l * longint'(LN2_Q30)) >>> 30;
      k = (r * ln) >>> 16;
      wh = w >>> 16;
      wl = w - wh * 65536;
      return (k * wh + ((k * wl) >>> 16)) >>> 16;
   endfunction

   function automatic warp_word_type predict_warp(logic [PIX_W-1:0] pix_x,
                                                  logic [PIX_W-1:0] pix_y);
      warp_word_type res;
      longint px, py, au, av, su, sv, dx, dy, r, mu, mv;
      int     n;
      px = longint'(pix_x);
      py = longint'(pix_y);
      au = longint'(affine.u_offset) * 256 + longint'(affine.u_x) * px
         + longint'(affine.u_y) * py;
      av = longint'(affine.v_offset) * 256 + longint'(affine.v_x) * px
         + longint'(affine.v_y) * py;
      n = (int'(num_points) > MAX_POINTS) ? MAX_POINTS : int'(num_points);
      su = 0;
      sv = 0;
      for (int j = 0; j < n; j++) begin
         dx = px * 16 - longint'(point_table[j].px);
         dy = py * 16 - longint'(point_table[j].py);
         r = dx * dx + dy * dy;
         su += kernel_term(r, longint'(point_table[j].wu));
         sv += kernel_term(r, longint'(point_table[j].wv));
      end
      mu = (au >>> 16) + su;
      mv = (av >>> 16) + sv;
      res.sat = 1'b0;
      if (mu > 8388607) begin mu = 8388607; res.sat = 1'b1; end
      if (mu < -8388608) begin mu = -8388608; res.sat = 1'b1; end
      if (mv > 8388607) begin mv = 8388607; res.sat = 1'b1; end
      if (mv < -8388608) begin mv = -8388608; res.sat = 1'b1; end
      res.map_u = mu[OUT_W-1:0];
      res.map_v = mv[OUT_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      warp_word_type want;
      logic [2:0] reg_idx;
      if (reset) begin
         num_points <= '0;
         affine <= '{u_offset: '0, u_x: AFF_ONE, u_y: '0,
                     v_offset: '0, v_x: '0, v_y: AFF_ONE};
         expected_warps.delete();
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            reg_idx = csr_paddr[ADDR_W-1:2];
            case (reg_idx)
               REG_NUM_POINTS: num_points <= csr_pwdata[NUM_W-1:0];
               REG_U_OFFSET: affine.u_offset <= csr_pwdata;
               REG_U_X: affine.u_x <= csr_pwdata;
               REG_U_Y: affine.u_y <= csr_pwdata;
               REG_V_OFFSET: affine.v_offset <= csr_pwdata;
               REG_V_X: affine.v_x <= csr_pwdata;
               REG_V_Y: affine.v_y <= csr_pwdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_type == REQ_LOAD) begin
               if (int'(req_entry_index) < MAX_POINTS)
                  point_table[req_entry_index] <= '{px: req_point_x, py: req_point_y,
                                                    wu: req_weight_u, wv: req_weight_v};
            end else begin
               expected_warps.push_back(predict_warp(req_pixel_x, req_pixel_y));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_warps.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result word u=%0d v=%0d sat=%0b",
                           rsp_map_u, rsp_map_v, rsp_saturated);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_warps.pop_front();
               if (want.map_u !== rsp_map_u || want.map_v !== rsp_map_v ||
                   want.sat !== rsp_saturated) begin
                  if (fail_count < 10)
                     $display("mismatch: expected u=%0d v=%0d sat=%0b, got u=%0d v=%0d sat=%0b",
                              want.map_u, want.map_v, want.sat,
                              rsp_map_u, rsp_map_v, rsp_saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives load and evaluate words and register writes into the spline warp
// core under random idling and back-pressure; the checker beside it judges.
// ----------------------------------------------------------------------------
module tb_top;
   import tpsw_pkg::*;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_type;
   logic [IDX_W-1:0]        req_entry_index;
   logic [PT_W-1:0]         req_point_x;
   logic [PT_W-1:0]         req_point_y;
   logic signed [WGT_W-1:0] req_weight_u;
   logic signed [WGT_W-1:0] req_weight_v;
   logic [PIX_W-1:0]        req_pixel_x;
   logic [PIX_W-1:0]        req_pixel_y;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [OUT_W-1:0] rsp_map_u;
   logic signed [OUT_W-1:0] rsp_map_v;
   logic                    rsp_saturated;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [ADDR_W-1:0]       csr_paddr;
   logic [CFG_W-1:0]        csr_pwdata;
   logic [CFG_W-1:0]        csr_prdata;
   logic                    csr_pready;
   int                      fail_count;
   int                      pending;
   logic                    quiet;
   logic                    hold_output;

   thin_plate_spline_warp_eval_core DUT (.*);

   tps_warp_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("tb_top failed");
      $finish;
   end

   // Result side back-pressure; one long hold-off lets the core back up.
   initial begin
      int n;
      logic held;
      held = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_output && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            for (n = 0; n < 4000; n++) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   function automatic logic signed [WGT_W-1:0] rand_weight();
      logic signed [WGT_W-1:0] w;
      w = WGT_W'({$urandom, $urandom});
      return w >>> $urandom_range(0, WGT_W - 1);
   endfunction

   function automatic logic [CFG_W-1:0] rand_coef();
      logic signed [CFG_W-1:0] c;
      c = $urandom;
      case ($urandom_range(0, 3))
         0: return c;
         1: return AFF_ONE + (c >>> 12);
         2: return -AFF_ONE + (c >>> 10);
         default: return c >>> $urandom_range(4, 31);
      endcase
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic send_word(logic kind, logic [IDX_W-1:0] slot,
                            logic [PT_W-1:0] pt_x, logic [PT_W-1:0] pt_y,
                            logic signed [WGT_W-1:0] w_u,
                            logic signed [WGT_W-1:0] w_v,
                            logic [PIX_W-1:0] pix_x, logic [PIX_W-1:0] pix_y);
      req_valid <= 1'b1;
      req_type <= kind;
      req_entry_index <= slot;
      req_point_x <= pt_x;
      req_point_y <= pt_y;
      req_weight_u <= w_u;
      req_weight_v <= w_v;
      req_pixel_x <= pix_x;
      req_pixel_y <= pix_y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic send_load(logic [IDX_W-1:0] slot, logic [PT_W-1:0] pt_x,
                            logic [PT_W-1:0] pt_y, logic signed [WGT_W-1:0] w_u,
                            logic signed [WGT_W-1:0] w_v);
      send_word(REQ_LOAD, slot, pt_x, pt_y, w_u, w_v,
                PIX_W'($urandom), PIX_W'($urandom));
   endtask

   task automatic send_eval(logic [PIX_W-1:0] pix_x, logic [PIX_W-1:0] pix_y);
      send_word(REQ_EVAL, IDX_W'($urandom), PT_W'($urandom), PT_W'($urandom),
                rand_weight(), rand_weight(), pix_x, pix_y);
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int n_items;
      int wait_cycles;
      logic [NUM_W-1:0] npts;
      quiet = 1'b0;
      hold_output = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= REQ_LOAD;
      req_entry_index <= '0;
      req_point_x <= '0;
      req_point_y <= '0;
      req_weight_u <= '0;
      req_weight_v <= '0;
      req_pixel_x <= '0;
      req_pixel_y <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: identity map with no points.
      send_eval(12'd0, 12'd0);
      send_eval(12'hFFF, 12'hFFF);

      // Every slot gets written before any evaluation can read it.
      for (int i = 0; i < DEFAULT_MAX_POINTS; i++)
         send_load(IDX_W'(i), PT_W'($urandom), PT_W'($urandom), rand_weight(),
                   rand_weight());
      idle_sender();
      wait_idle();

      // Directed: a point on the pixel, extreme weights and coordinates.
      write_reg(REG_NUM_POINTS, CFG_W'(3));
      send_load(6'd0, 16'd1600, 16'd3200, 40'sh7F_FFFF_FFFF, 40'sh80_0000_0000);
      send_load(6'd1, 16'hFFFF, 16'hFFFF, 40'sh80_0000_0000, 40'sh7F_FFFF_FFFF);
      send_load(6'd2, 16'd0, 16'd0, 40'sh00_0001_0000, -40'sh00_0001_0000);
      send_eval(12'd100, 12'd200);
      send_eval(12'd0, 12'd0);
      send_eval(12'hFFF, 12'hFFF);
      send_eval(12'hFFF, 12'd0);
      idle_sender();
      wait_idle();
      write_reg(REG_U_OFFSET, 32'h7FFF_FFFF);
      write_reg(REG_V_OFFSET, 32'h8000_0000);
      write_reg(REG_U_X, 32'h7FFF_FFFF);
      write_reg(REG_V_Y, 32'h8000_0000);
      write_reg(REG_U_Y, 32'h8000_0000);
      write_reg(REG_V_X, 32'h7FFF_FFFF);
      send_eval(12'hFFF, 12'hFFF);
      send_eval(12'd0, 12'hFFF);
      send_eval(12'd100, 12'd200);
      idle_sender();
      wait_idle();
      write_reg(REG_NUM_POINTS, '0);
      send_eval(12'd5, 12'd7);
      idle_sender();
      wait_idle();

      for (int ph = 0; ph < 12; ph++) begin
         idle_sender();
         wait_idle();
         if (ph == 3) npts = NUM_W'(64);
         else if (ph == 5) npts = NUM_W'(127);
         else npts = NUM_W'($urandom_range(0, 8));
         write_reg(REG_NUM_POINTS, CFG_W'(npts));
         write_reg(REG_U_OFFSET, rand_coef());
         write_reg(REG_U_X, rand_coef());
         write_reg(REG_U_Y, rand_coef());
         write_reg(REG_V_OFFSET, rand_coef());
         write_reg(REG_V_X, rand_coef());
         write_reg(REG_V_Y, rand_coef());
         if (ph == 11) quiet = 1'b1;
         if (ph == 1) hold_output = 1'b1;
         n_items = (npts > 8) ? 8 : 105;
         for (int k = 0; k < n_items; k++) begin
            if (ph == 6 && k == 50) begin
               idle_sender();
               while (pending != 0) @(posedge clock);
            end
            if ($urandom_range(0, 9) < 4)
               send_load(IDX_W'($urandom), PT_W'($urandom), PT_W'($urandom),
                         rand_weight(), rand_weight());
            else
               send_eval(PIX_W'($urandom), PIX_W'($urandom));
         end
      end
      idle_sender();

      wait_cycles = 0;
      while (pending != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/tpsw_pkg.sv
hdl/tpsw_ctl.sv
hdl/tpsw_dp.sv
hdl/thin_plate_spline_warp_eval_core.sv
sim/tps_warp_checker.sv
sim/tb_top.sv
